// File: sv/energy_rise_onset_detector_defines.svh
// Assertion macros for the energy rise onset detector.
// No dependencies; included by files that carry concurrent checks.
`ifndef ENERGY_RISE_ONSET_DETECTOR_DEFINES_SVH
`define ENERGY_RISE_ONSET_DETECTOR_DEFINES_SVH

`ifndef SYNTHESIS
`define EROD_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("check failed: lbl");
`define EROD_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
        else $error("forbidden condition: lbl");
`else
`define EROD_ASSERT(lbl, clk, rstn, prop)
`define EROD_NEVER(lbl, clk, rstn, cond)
`endif

`endif

// File: sv/erod_pkg.sv
// Shared constants, types and helpers for the energy rise onset detector.
// No dependencies.
package erod_pkg;

    localparam int WIN_MIN   = 4;
    localparam int WIN_MAX   = 256;
    localparam int SEG_MAX   = 65536;
    localparam int DLY_DEPTH = 2 * WIN_MAX;
    localparam int DLY_AW    = $clog2(DLY_DEPTH);
    localparam int CNT_W     = $clog2(SEG_MAX) + 1;
    localparam int WIN_W     = 9;
    localparam int HOP_W     = 8;
    localparam int SMP_W     = 16;
    localparam int SQ_W      = 31;
    localparam int EN_W      = 39;
    localparam int OFF_W     = 16;
    localparam int POS_W     = 32;
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;
    localparam int S_TD_W    = 16;
    localparam int M_TD_W    = 80;

    localparam logic REG_WINDOW   = 1'b0;
    localparam logic REG_SEGSTART = 1'b1;

    typedef struct packed {
        logic             vld;
        logic             act;
        logic             ge_w;
        logic             ge_2w;
        logic             cand;
        logic             last;
        logic             ovf;
        logic [OFF_W-1:0] offset;
    } t_erod_item;

    typedef struct packed {
        logic             vld;
        logic             ovf;
        logic [EN_W-1:0]  rise;
        logic [OFF_W-1:0] offset;
    } t_erod_res;

    function automatic logic [SQ_W-1:0] sq_of(input logic [SMP_W-1:0] raw);
        logic [SMP_W-1:0]   mag;
        logic [2*SMP_W-1:0] prod;
        mag  = raw[SMP_W-1] ? (~raw + 1'b1) : raw;
        prod = {{SMP_W{1'b0}}, mag} * {{SMP_W{1'b0}}, mag};
        return prod[SQ_W-1:0];
    endfunction

endpackage

// File: sv/erod_energy.sv
// Energy datapath: squares of the three taps, sliding window sums, best rise.
// Depends on erod_pkg.
module erod_energy (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  erod_pkg::t_erod_item            i_item,
    input  logic [erod_pkg::SMP_W-1:0]      i_smp_new,
    input  logic [erod_pkg::SMP_W-1:0]      i_smp_mid,
    input  logic [erod_pkg::SMP_W-1:0]      i_smp_old,
    output erod_pkg::t_erod_res             o_res
);
    import erod_pkg::*;

    t_erod_item      r_item;
    logic [SQ_W-1:0] r_sq_new, r_sq_mid, r_sq_old;

    logic [EN_W-1:0]  r_cur, r_prev, r_best;
    logic [OFF_W-1:0] r_best_off;
    t_erod_res        r_res;

    logic [EN_W-1:0]  n_cur, n_prev, n_best, w_rise, w_mid, w_old;
    logic [OFF_W-1:0] n_best_off;
    logic             w_upd;

    // stage A: squares
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item <= '0;
        end else begin
            r_item <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sq_new <= sq_of(i_smp_new);
        r_sq_mid <= sq_of(i_smp_mid);
        r_sq_old <= sq_of(i_smp_old);
    end

    // stage B: sums and best tracking
    always_comb begin
        w_mid      = r_item.ge_w  ? {{(EN_W-SQ_W){1'b0}}, r_sq_mid} : '0;
        w_old      = r_item.ge_2w ? {{(EN_W-SQ_W){1'b0}}, r_sq_old} : '0;
        w_rise     = r_cur - r_prev;
        w_upd      = r_item.cand && (r_cur > r_prev) && (w_rise > r_best);
        n_cur      = r_cur;
        n_prev     = r_prev;
        n_best     = r_best;
        n_best_off = r_best_off;
        if (r_item.vld && r_item.act) begin
            n_cur  = r_cur + {{(EN_W-SQ_W){1'b0}}, r_sq_new} - w_mid;
            n_prev = r_prev + w_mid - w_old;
            if (w_upd) begin
                n_best     = w_rise;
                n_best_off = r_item.offset;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur      <= '0;
            r_prev     <= '0;
            r_best     <= '0;
            r_best_off <= '0;
            r_res      <= '0;
        end else begin
            r_res.vld <= r_item.vld && r_item.last;
            if (r_item.vld && r_item.last) begin
                r_res.ovf    <= r_item.ovf;
                r_res.rise   <= n_best;
                r_res.offset <= n_best_off;
                r_cur        <= '0;
                r_prev       <= '0;
                r_best       <= '0;
                r_best_off   <= '0;
            end else begin
                r_cur      <= n_cur;
                r_prev     <= n_prev;
                r_best     <= n_best;
                r_best_off <= n_best_off;
            end
        end
    end

    assign o_res = r_res;

endmodule

// File: sv/energy_rise_onset_detector.sv
// Top level of the energy rise onset detector: APB registers, sample delay
// memory, segment sequencing and result buffering. Depends on erod_pkg,
// erod_energy and energy_rise_onset_detector_defines.svh.
//
// One signed sample is taken per clock on the slave stream; tlast marks the
// final sample of a segment. The window energies over [i-W, i) and [i, i+W)
// slide by one sample per accepted sample using a 512x16 delay memory with
// one write and two registered reads. When a segment ends, one result word
// (absolute onset position, peak rise, found flag, overflow flag) reaches the
// master stream, registered in turn by the input stage, the energy stages and
// the output register. Up to two results may be outstanding; with two unread
// the slave side stalls. window_size is sampled at a segment's first sample.
// There is no clearing pass after reset: taps not yet written are never used.
`include "energy_rise_onset_detector_defines.svh"

module energy_rise_onset_detector (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // APB
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [erod_pkg::APB_AW-1:0]      paddr,
    input  logic [erod_pkg::APB_DW-1:0]      pwdata,
    output logic [erod_pkg::APB_DW-1:0]      prdata,
    output logic                             pready,
    // slave stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [erod_pkg::S_TD_W-1:0]      s_tdata,   // [15:0] sample
    input  logic                             s_tlast,   // last_sample
    // master stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [erod_pkg::M_TD_W-1:0]      m_tdata    // [31:0] onset_position,
                                                        // [70:32] peak_rise,
                                                        // [71] rise_found,
                                                        // [72] segment_overflow
);
    import erod_pkg::*;

    // registers
    logic [WIN_W-1:0] r_cfg_win;
    logic [POS_W-1:0] r_cfg_seg;
    logic             w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_win <= WIN_W'(44);
            r_cfg_seg <= '0;
        end else if (w_wr) begin
            case (paddr[2])
                REG_WINDOW:   r_cfg_win <= pwdata[WIN_W-1:0];
                REG_SEGSTART: r_cfg_seg <= pwdata[POS_W-1:0];
                default:      r_cfg_seg <= r_cfg_seg;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_WINDOW:   prdata = {{(APB_DW-WIN_W){1'b0}}, r_cfg_win};
            REG_SEGSTART: prdata = r_cfg_seg;
            default:      prdata = '0;
        endcase
    end

    // segment sequencing
    logic [CNT_W-1:0]  r_cnt;
    logic [HOP_W-1:0]  r_hop;
    logic [WIN_W-1:0]  r_win;
    logic              r_ovf;
    logic [1:0]        r_pend;

    logic              w_acc, w_in_rng, w_ge_w, w_ge_2w, w_hop_wrap;
    logic [WIN_W-1:0]  w_cfg_win, w_win;
    logic [HOP_W-1:0]  w_hop, n_hop;
    logic [CNT_W-1:0]  w_two_w, w_off;
    logic [DLY_AW-1:0] w_a_new, w_a_mid, w_a_old;
    t_erod_item        w_item;

    assign s_tready = !r_pend[1];
    assign w_acc    = s_tvalid && s_tready;
    assign w_in_rng = (r_cnt < CNT_W'(SEG_MAX));

    always_comb begin
        w_cfg_win = r_cfg_win;
        if (r_cfg_win < WIN_W'(WIN_MIN)) w_cfg_win = WIN_W'(WIN_MIN);
        if (r_cfg_win > WIN_W'(WIN_MAX)) w_cfg_win = WIN_W'(WIN_MAX);
        w_win      = (r_cnt == '0) ? w_cfg_win : r_win;
        w_hop      = w_win[WIN_W-1:1];
        w_two_w    = {{(CNT_W-WIN_W-1){1'b0}}, w_win, 1'b0};
        w_ge_w     = r_cnt >= {{(CNT_W-WIN_W){1'b0}}, w_win};
        w_ge_2w    = r_cnt >= w_two_w;
        w_hop_wrap = ({1'b0, r_hop} + 9'd1) >= {1'b0, w_hop};
        n_hop      = w_hop_wrap ? '0 : r_hop + 1'b1;
        w_off      = r_cnt - {{(CNT_W-WIN_W){1'b0}}, w_win};
        w_a_new    = r_cnt[DLY_AW-1:0];
        w_a_mid    = r_cnt[DLY_AW-1:0] - w_win[DLY_AW-1:0];
        w_a_old    = r_cnt[DLY_AW-1:0] - w_two_w[DLY_AW-1:0];

        w_item        = '0;
        w_item.vld    = w_acc;
        w_item.act    = w_in_rng;
        w_item.ge_w   = w_ge_w;
        w_item.ge_2w  = w_ge_2w;
        w_item.cand   = w_ge_2w && (r_hop == '0);
        w_item.last   = s_tlast;
        w_item.ovf    = r_ovf || !w_in_rng;
        w_item.offset = w_off[OFF_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_hop <= '0;
            r_win <= WIN_W'(WIN_MIN);
            r_ovf <= 1'b0;
        end else if (w_acc) begin
            if (s_tlast) begin
                r_cnt <= '0;
                r_hop <= '0;
                r_ovf <= 1'b0;
            end else if (w_in_rng) begin
                r_cnt <= r_cnt + 1'b1;
                r_win <= w_win;
                if (w_ge_2w) r_hop <= n_hop;
            end else begin
                r_ovf <= 1'b1;
            end
        end
    end

    // delay memory, read before write
    logic [SMP_W-1:0] r_dly [DLY_DEPTH];
    logic [SMP_W-1:0] r_rd_mid, r_rd_old, r_smp;
    t_erod_item       r_st1;

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_rd_mid <= r_dly[w_a_mid];
            r_rd_old <= r_dly[w_a_old];
            r_smp    <= s_tdata[SMP_W-1:0];
            if (w_in_rng) r_dly[w_a_new] <= s_tdata[SMP_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st1 <= '0;
        end else begin
            r_st1 <= w_item;
        end
    end

    t_erod_res w_res;

    erod_energy u_energy (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_item    (r_st1),
        .i_smp_new (r_smp),
        .i_smp_mid (r_rd_mid),
        .i_smp_old (r_rd_old),
        .o_res     (w_res)
    );

    // result buffering
    t_erod_res         r_hold, w_src;
    logic              r_m_tvalid, w_out_free, w_load, w_dec, w_inc;
    logic [M_TD_W-1:0] r_m_tdata;
    logic [POS_W-1:0]  w_pos;

    assign w_out_free = !r_m_tvalid || m_tready;
    assign w_src      = r_hold.vld ? r_hold : w_res;
    assign w_load     = w_out_free && w_src.vld;
    assign w_pos      = r_cfg_seg + {{(POS_W-OFF_W){1'b0}}, w_src.offset};
    assign w_inc      = w_acc && s_tlast;
    assign w_dec      = r_m_tvalid && m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold     <= '0;
            r_m_tvalid <= 1'b0;
            r_pend     <= '0;
        end else begin
            if (r_hold.vld) begin
                if (w_out_free) r_hold <= w_res;
            end else if (!w_out_free) begin
                r_hold <= w_res;
            end
            if (w_load) r_m_tvalid <= 1'b1;
            else if (m_tready) r_m_tvalid <= 1'b0;
            r_pend <= r_pend + {1'b0, w_inc} - {1'b0, w_dec};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_m_tdata <= {{(M_TD_W-POS_W-EN_W-2){1'b0}}, w_src.ovf, |w_src.rise,
                          w_src.rise, w_pos};
        end
    end

    assign m_tvalid = r_m_tvalid;
    assign m_tdata  = r_m_tdata;

    // checks
    `EROD_ASSERT(a_pend_bound, i_clk, i_rst_n, r_pend <= 2'd2)
    `EROD_NEVER(a_res_lost, i_clk, i_rst_n, w_res.vld && r_hold.vld && !w_out_free)
    `EROD_ASSERT(a_pend_inc, i_clk, i_rst_n, (w_inc && !w_dec) |=> (r_pend == $past(r_pend) + 2'd1))

endmodule

// File: dv/tb_top.sv
// Self-checking bench for energy_rise_onset_detector: APB register set-up,
// sample words in, onset results out, each result checked against a local predictor
// of the window energies or a preset result. Depends on erod_pkg and the RTL only.
`timescale 1ns / 100ps

module tb_top;
    import erod_pkg::*;

    localparam int LAT_CYC     = 6;
    localparam int HOLD_CYC    = 300;
    localparam int PHASE_ITEMS = 110;
    localparam int SHORT_WIN   = 24;
    localparam longint unsigned E_MASK = 64'h7F_FFFF_FFFF;

    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic [EN_W-1:0]  rise;
        logic             found;
        logic             ovf;
    } t_onset;

    typedef struct {
        bit               cfg_en;
        logic             cfg_reg;
        logic [31:0]      cfg_val;
        logic [SMP_W-1:0] smp;
        bit               lst;
        bit               typed;
        logic [POS_W-1:0] typed_pos;
    } t_stim_row;

    logic                i_clk     = 1'b0;
    logic                i_rst_n   = 1'b0;
    logic                psel      = 1'b0;
    logic                penable   = 1'b0;
    logic                pwrite    = 1'b0;
    logic [APB_AW-1:0]   paddr     = '0;
    logic [APB_DW-1:0]   pwdata    = '0;
    logic [APB_DW-1:0]   prdata;
    logic                pready;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [S_TD_W-1:0]   s_tdata   = '0;   // [15:0] sample
    logic                s_tlast   = 1'b0; // last_sample
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [M_TD_W-1:0]   m_tdata;          // [31:0] onset_position, [70:32] peak_rise,
                                           // [71] rise_found, [72] segment_overflow

    energy_rise_onset_detector dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // predictor state
    logic [8:0]        win_reg  = 9'd44;
    logic [31:0]       seg_base = '0;
    logic [SMP_W-1:0]  ring [DLY_DEPTH];
    longint unsigned   e_now, e_prior, top_rise;
    int unsigned       taken, hop_pos, top_off, seg_win;
    bit                over_flag;

    t_onset    onset_queue [$];
    t_stim_row stim_rows [$];
    t_onset    want_onset;
    int        errors       = 0;
    int        fed          = 0;
    int        src_idle_pct = 0;
    int        snk_idle_pct = 0;
    int        hold_reqs    = 0;
    int        hold_seen    = 0;
    int        hold_left    = 0;

    function automatic int unsigned clamp_window(input logic [8:0] w);
        if (w < WIN_MIN) return WIN_MIN;
        if (w > WIN_MAX) return WIN_MAX;
        return {23'd0, w};
    endfunction

    function automatic longint unsigned energy_of(input logic [SMP_W-1:0] raw);
        longint unsigned mag;
        mag = raw[SMP_W-1] ? (64'h10000 - raw) : raw;
        return mag * mag;
    endfunction

    function automatic void onset_clear();
        e_now = 0;
        e_prior = 0;
        taken = 0;
        hop_pos = 0;
        top_rise = 0;
        top_off = 0;
        over_flag = 0;
        seg_win = WIN_MIN;
    endfunction

    function automatic bit onset_predict(input logic [SMP_W-1:0] s, input bit lst,
                                         output t_onset r);
        int unsigned     n, w;
        longint unsigned mid;
        r = '0;
        if (taken >= SEG_MAX) begin
            over_flag = 1'b1;
        end else begin
            n = taken;
            if (n == 0)
                seg_win = clamp_window(win_reg);
            w = seg_win;
            if (n >= 2 * w) begin
                if (hop_pos == 0 && e_now > e_prior && e_now - e_prior > top_rise) begin
                    top_rise = e_now - e_prior;
                    top_off = n - w;
                end
                hop_pos = (hop_pos + 1 >= w / 2) ? 0 : hop_pos + 1;
            end
            e_now += energy_of(s);
            if (n >= w) begin
                mid = energy_of(ring[(n - w) % DLY_DEPTH]);
                e_now -= mid;
                e_prior += mid;
                if (n >= 2 * w)
                    e_prior -= energy_of(ring[(n - 2 * w) % DLY_DEPTH]);
            end
            e_now &= E_MASK;
            e_prior &= E_MASK;
            ring[n % DLY_DEPTH] = s;
            taken = n + 1;
        end
        if (!lst)
            return 1'b0;
        r.pos = seg_base + 32'(top_off);
        r.rise = top_rise[EN_W-1:0];
        r.found = (top_rise != 0);
        r.ovf = over_flag;
        onset_clear();
        return 1'b1;
    endfunction

    function automatic void add_row(input int cfg_en, input logic cfg_reg,
                                    input logic [31:0] cfg_val, input logic [SMP_W-1:0] smp,
                                    input int lst, input int typed,
                                    input logic [POS_W-1:0] typed_pos);
        t_stim_row row;
        row.cfg_en = (cfg_en != 0);
        row.cfg_reg = cfg_reg;
        row.cfg_val = cfg_val;
        row.smp = smp;
        row.lst = (lst != 0);
        row.typed = (typed != 0);
        row.typed_pos = typed_pos;
        stim_rows = {stim_rows, row};
    endfunction

    // receiver: random back-pressure, plus a long hold on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else if (hold_seen != hold_reqs) begin
            hold_seen <= hold_reqs;
            hold_left <= HOLD_CYC;
            m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= (snk_idle_pct == 0) || ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) begin
            if (onset_queue.size() == 0) begin
                $display("%0t: unexpected result word %h", $time, m_tdata);
                errors++;
            end else begin
                want_onset = onset_queue.pop_front();
                if (m_tdata[31:0] !== want_onset.pos) begin
                    $display("%0t: onset_position expected %h got %h", $time,
                             want_onset.pos, m_tdata[31:0]);
                    errors++;
                end
                if (m_tdata[70:32] !== want_onset.rise) begin
                    $display("%0t: peak_rise expected %h got %h", $time,
                             want_onset.rise, m_tdata[70:32]);
                    errors++;
                end
                if (m_tdata[71] !== want_onset.found) begin
                    $display("%0t: rise_found expected %b got %b", $time,
                             want_onset.found, m_tdata[71]);
                    errors++;
                end
                if (m_tdata[72] !== want_onset.ovf) begin
                    $display("%0t: segment_overflow expected %b got %b", $time,
                             want_onset.ovf, m_tdata[72]);
                    errors++;
                end
            end
        end
    end

    task automatic push_word(input logic [SMP_W-1:0] smp, input bit lst,
                             input bit typed, input t_onset typed_exp);
        t_onset r;
        while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= smp;
        s_tlast <= lst;
        @(posedge i_clk);
        while (!s_tready)
            @(posedge i_clk);
        fed++;
        if (onset_predict(smp, lst, r))
            onset_queue = {onset_queue, (typed ? typed_exp : r)};
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (onset_queue.size() != 0)
            @(posedge i_clk);
        repeat (LAT_CYC) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic which, input logic [31:0] val);
        logic [31:0] got, want;
        paddr <= {which, 2'b00};
        pwdata <= val;
        pwrite <= 1'b1;
        psel <= 1'b1;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        got = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        if (which == REG_WINDOW) begin
            win_reg = val[8:0];
            want = {23'd0, val[8:0]};
        end else begin
            seg_base = val;
            want = val;
        end
        if (got !== want) begin
            $display("%0t: register %0d readback expected %h got %h", $time, which, want, got);
            errors++;
        end
        @(posedge i_clk);
    endtask

    // quiet or silent lead-in then a louder or constant part, or plain noise
    task automatic send_segment(input int len);
        int               pre, style, qsh, lsh, k;
        logic [SMP_W-1:0] cval, smp;
        pre = $urandom_range(0, len - 1);
        style = $urandom_range(3);
        qsh = $urandom_range(6, 15);
        lsh = $urandom_range(0, 4);
        cval = 16'($urandom);
        for (k = 0; k < len; k++) begin
            if (style == 0)
                smp = 16'($urandom);
            else if (k < pre)
                smp = (style == 3) ? '0 : $signed(16'($urandom)) >>> qsh;
            else if (style == 2)
                smp = cval;
            else
                smp = $signed(16'($urandom)) >>> lsh;
            push_word(smp, k == len - 1, 1'b0, '0);
        end
    endtask

    task automatic run_phase(input int src_pct, input int snk_pct);
        int fed0, w, len;
        src_idle_pct = src_pct;
        snk_idle_pct <= snk_pct;
        fed0 = fed;
        while (fed - fed0 < PHASE_ITEMS) begin
            if ($urandom_range(3) == 0) begin
                settle();
                if ($urandom_range(1)) begin
                    case ($urandom_range(9))
                        0, 1, 2, 3, 4, 5: w = $urandom_range(4, 12);
                        6:                w = $urandom_range(0, 40);
                        7:                w = $urandom_range(0, 511);
                        default: begin
                            case ($urandom_range(6))
                                0: w = 0;
                                1: w = 3;
                                2: w = 4;
                                3: w = 5;
                                4: w = 256;
                                5: w = 257;
                                default: w = 511;
                            endcase
                        end
                    endcase
                    cfg_write(REG_WINDOW, 32'(w));
                end
                if ($urandom_range(1)) begin
                    case ($urandom_range(3))
                        0: cfg_write(REG_SEGSTART, 32'd0);
                        1: cfg_write(REG_SEGSTART, 32'hFFFF_FFFF - $urandom_range(0, 2000));
                        default: cfg_write(REG_SEGSTART, $urandom);
                    endcase
                end
            end
            w = clamp_window(win_reg);
            if (w > SHORT_WIN)
                len = $urandom_range(1, SHORT_WIN);
            else
                len = ($urandom_range(99) < 15) ? $urandom_range(1, 2 * w)
                                                : $urandom_range(2 * w + 1, 4 * w + 8);
            send_segment(len);
        end
    endtask

    initial begin
        #4_000_000;
        $display("energy_rise_onset_detector verification failed");
        $finish;
    end

    initial begin
        t_stim_row row;
        t_onset    fixed;
        int        k;
        onset_clear();

        // defaults after reset, then wrapped base
        add_row(0, REG_WINDOW,   0,            16'h0000, 1, 1, 32'h0000_0000);
        add_row(1, REG_SEGSTART, 32'hFFFF_FFFE, 16'h7FFF, 1, 1, 32'hFFFF_FFFE);
        // window below minimum, full-scale samples, onset offset wraps past 2^32
        add_row(1, REG_WINDOW,   3,            16'h0000, 0, 0, 0);
        add_row(0, REG_WINDOW,   0,            16'h0000, 0, 0, 0);
        add_row(0, REG_WINDOW,   0,            16'h0000, 0, 0, 0);
        add_row(0, REG_WINDOW,   0,            16'h0000, 0, 0, 0);
        add_row(0, REG_WINDOW,   0,            16'h8000, 0, 0, 0);
        add_row(0, REG_WINDOW,   0,            16'h7FFF, 0, 0, 0);
        add_row(0, REG_WINDOW,   0,            16'hFFFF, 0, 0, 0);
        add_row(0, REG_WINDOW,   0,            16'h0001, 0, 0, 0);
        add_row(0, REG_WINDOW,   0,            16'h0000, 0, 0, 0);
        add_row(0, REG_WINDOW,   0,            16'h0000, 0, 0, 0);
        add_row(0, REG_WINDOW,   0,            16'h0000, 0, 0, 0);
        add_row(0, REG_WINDOW,   0,            16'h0005, 1, 0, 0);
        // window above maximum latched, then rewritten mid-segment
        add_row(1, REG_WINDOW,   511,          16'h0064, 0, 0, 0);
        add_row(1, REG_WINDOW,   4,            16'h0000, 0, 0, 0);
        add_row(0, REG_WINDOW,   0,            16'h0000, 0, 0, 0);
        add_row(0, REG_WINDOW,   0,            16'h0000, 0, 0, 0);
        add_row(0, REG_WINDOW,   0,            16'h4000, 0, 0, 0);
        add_row(0, REG_WINDOW,   0,            16'hC000, 0, 0, 0);
        add_row(0, REG_WINDOW,   0,            16'h4000, 0, 0, 0);
        add_row(0, REG_WINDOW,   0,            16'hC000, 0, 0, 0);
        add_row(0, REG_WINDOW,   0,            16'h4000, 0, 0, 0);
        add_row(0, REG_WINDOW,   0,            16'hC000, 0, 0, 0);
        add_row(0, REG_WINDOW,   0,            16'h1234, 1, 0, 0);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        src_idle_pct = 20;
        snk_idle_pct <= 20;
        foreach (stim_rows[k]) begin
            row = stim_rows[k];
            if (row.cfg_en) begin
                settle();
                cfg_write(row.cfg_reg, row.cfg_val);
            end
            fixed = '0;
            fixed.pos = row.typed_pos;
            push_word(row.smp, row.lst, row.typed, fixed);
        end

        // long receiver hold while one-word segments keep coming
        settle();
        src_idle_pct = 0;
        snk_idle_pct <= 0;
        hold_reqs <= hold_reqs + 1;
        for (k = 0; k < 8; k++)
            push_word(16'($urandom), 1'b1, 1'b0, '0);
        settle();

        run_phase(34, 45);
        run_phase(45, 34);
        run_phase(0, 0);

        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (onset_queue.size() != 0)
            @(posedge i_clk);
        repeat (4 * LAT_CYC) @(posedge i_clk);
        if (errors == 0)
            $display("energy_rise_onset_detector verification clean");
        else
            $display("energy_rise_onset_detector verification failed");
        $finish;
    end

endmodule
